// ----- design/mchd_pkg.sv -----
// ============================================================================
// Mouse click and hold detector package
// Shared widths, register indexes and the types passed between the modules.
// ============================================================================
package mchd_pkg;

    localparam int NUM_BUTTONS_DEF = 5;
    localparam int TIME_BITS_DEF   = 32;

    localparam int OUT_LANES  = 5;
    localparam int POS_W      = 16;
    localparam int COUNT_W    = 4;
    localparam int DLY_W      = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd15;
    localparam logic [COUNT_W-1:0] CLICKS_INIT = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_DELAY   = 4'd0,
        REG_MULTI_DELAY  = 4'd1,
        REG_BUTTON_EN    = 4'd2,
        REG_MAX_LEFT     = 4'd3,
        REG_MAX_RIGHT    = 4'd4,
        REG_MAX_MIDDLE   = 4'd5,
        REG_MAX_FOURTH   = 4'd6,
        REG_MAX_FIFTH    = 4'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [DLY_W-1:0]                   hold_delay;
        logic [DLY_W-1:0]                   multi_delay;
        logic [OUT_LANES-1:0]               button_en;
        logic [OUT_LANES-1:0][COUNT_W-1:0]  max_clicks;
    } t_cfg;

    typedef struct packed {
        logic               drag;
        logic               hold;
        logic               release_fired;
        logic               click;
        logic [COUNT_W-1:0] count;
    } t_lane_res;

endpackage

// ----- design/mchd_cfg.sv -----
// ============================================================================
// Configuration register file
// Holds the delays, the button enable mask and the per-button click limits.
// ============================================================================
module mchd_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic [mchd_pkg::CFG_IDX_W-1:0]    i_index,
    input  logic [mchd_pkg::CFG_DATA_W-1:0]   i_data,
    output mchd_pkg::t_cfg                    o_cfg
);

    mchd_pkg::t_cfg r_cfg;
    mchd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (mchd_pkg::t_cfg_reg'(i_index))
                mchd_pkg::REG_HOLD_DELAY:  n_cfg.hold_delay  = i_data[mchd_pkg::DLY_W-1:0];
                mchd_pkg::REG_MULTI_DELAY: n_cfg.multi_delay = i_data[mchd_pkg::DLY_W-1:0];
                mchd_pkg::REG_BUTTON_EN:   n_cfg.button_en   = i_data[mchd_pkg::OUT_LANES-1:0];
                mchd_pkg::REG_MAX_LEFT:    n_cfg.max_clicks[0] = i_data[mchd_pkg::COUNT_W-1:0];
                mchd_pkg::REG_MAX_RIGHT:   n_cfg.max_clicks[1] = i_data[mchd_pkg::COUNT_W-1:0];
                mchd_pkg::REG_MAX_MIDDLE:  n_cfg.max_clicks[2] = i_data[mchd_pkg::COUNT_W-1:0];
                mchd_pkg::REG_MAX_FOURTH:  n_cfg.max_clicks[3] = i_data[mchd_pkg::COUNT_W-1:0];
                mchd_pkg::REG_MAX_FIFTH:   n_cfg.max_clicks[4] = i_data[mchd_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_delay  <= '0;
            r_cfg.multi_delay <= '0;
            r_cfg.button_en   <= '0;
            for (int i = 0; i < mchd_pkg::OUT_LANES; i++) begin
                r_cfg.max_clicks[i] <= mchd_pkg::CLICKS_INIT;
            end
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/mchd_lane.sv -----
// ============================================================================
// Button gesture lane
// Click counter, hold flag and fire time of one button, with its next-state
// logic and the flags it raises for the event in flight.
// ============================================================================
module mchd_lane #(
    parameter int TIME_BITS = mchd_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_upd,
    input  logic                            i_en,
    input  logic                            i_now_btn,
    input  logic                            i_prev_btn,
    input  logic                            i_moved,
    input  logic [TIME_BITS-1:0]            i_now,
    input  logic [mchd_pkg::DLY_W-1:0]      i_hold_delay,
    input  logic [mchd_pkg::DLY_W-1:0]      i_multi_delay,
    input  logic [mchd_pkg::COUNT_W-1:0]    i_limit,
    output mchd_pkg::t_lane_res             o_res
);

    localparam int CMP_W = (TIME_BITS > mchd_pkg::DLY_W) ? TIME_BITS : mchd_pkg::DLY_W;

    logic [mchd_pkg::COUNT_W-1:0] r_count;
    logic [mchd_pkg::COUNT_W-1:0] n_count;
    logic                         r_hold;
    logic                         n_hold;
    logic [TIME_BITS-1:0]         r_fire;
    logic [TIME_BITS-1:0]         n_fire;
    logic [TIME_BITS-1:0]         w_elapsed;
    logic                         w_hold_due;
    logic                         w_multi_due;

    assign w_elapsed   = i_now - r_fire;
    assign w_hold_due  = CMP_W'(w_elapsed) >= CMP_W'(i_hold_delay);
    assign w_multi_due = CMP_W'(w_elapsed) >= CMP_W'(i_multi_delay);

    always_comb begin
        n_count = r_count;
        n_hold  = r_hold;
        n_fire  = r_fire;
        o_res   = '0;
        if (i_en) begin
            if (i_now_btn) begin
                o_res.drag = i_moved;
                if (!i_prev_btn) begin
                    if (r_count != mchd_pkg::COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                    n_fire = i_now;
                end else if (w_hold_due && r_count == mchd_pkg::COUNT_W'(1)) begin
                    o_res.hold = 1'b1;
                    n_hold     = 1'b1;
                    n_count    = '0;
                end
            end else if (r_hold) begin
                o_res.release_fired = 1'b1;
                n_hold              = 1'b0;
                n_fire              = i_now;
            end else if (r_count != '0) begin
                if (w_multi_due || r_count == i_limit) begin
                    o_res.click = 1'b1;
                    o_res.count = r_count;
                    n_count     = '0;
                end
                n_fire = i_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hold  <= 1'b0;
            r_fire  <= '0;
        end else if (i_upd) begin
            r_count <= n_count;
            r_hold  <= n_hold;
            r_fire  <= n_fire;
        end
    end

endmodule

// ----- design/mouse_click_hold_detector_unit.sv -----
// ============================================================================
// Mouse click and hold detector
// Turns mouse events into move, drag, hold, release and multi-click results.
// ============================================================================
// The block takes one event per clock cycle while the output is not stalled
// and returns exactly one result beat per event: the event is captured in an
// input register, all button lanes evaluate it in parallel with one subtract
// and two compares each, and the result lands in an output register while
// the lane state and previous position and buttons are updated in the same
// cycle. Configuration writes are taken at any time, but should only be
// issued while no event is in flight.
module mouse_click_hold_detector_unit #(
    parameter int NUM_BUTTONS = mchd_pkg::NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = mchd_pkg::TIME_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [mchd_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [mchd_pkg::POS_W-1:0]    i_pos_y,
    input  logic [mchd_pkg::OUT_LANES-1:0]       i_button_mask,
    input  logic [TIME_BITS-1:0]                 i_time_now,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_moved,
    output logic [mchd_pkg::OUT_LANES-1:0]       o_drag_mask,
    output logic [mchd_pkg::OUT_LANES-1:0]       o_hold_mask,
    output logic [mchd_pkg::OUT_LANES-1:0]       o_release_mask,
    output logic [mchd_pkg::OUT_LANES-1:0]       o_click_mask,
    output logic [mchd_pkg::COUNT_W-1:0]         o_count_left,
    output logic [mchd_pkg::COUNT_W-1:0]         o_count_right,
    output logic [mchd_pkg::COUNT_W-1:0]         o_count_middle,
    output logic [mchd_pkg::COUNT_W-1:0]         o_count_fourth,
    output logic [mchd_pkg::COUNT_W-1:0]         o_count_fifth,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mchd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mchd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int OL = mchd_pkg::OUT_LANES;

    mchd_pkg::t_cfg w_cfg;

    logic                          r_in_valid;
    logic signed [mchd_pkg::POS_W-1:0] r_in_x;
    logic signed [mchd_pkg::POS_W-1:0] r_in_y;
    logic [OL-1:0]                 r_in_btn;
    logic [TIME_BITS-1:0]          r_in_time;

    logic signed [mchd_pkg::POS_W-1:0] r_prev_x;
    logic signed [mchd_pkg::POS_W-1:0] r_prev_y;
    logic [OL-1:0]                 r_prev_btn;

    logic                          r_out_valid;
    logic                          r_moved;
    logic [OL-1:0]                 r_drag;
    logic [OL-1:0]                 r_hold;
    logic [OL-1:0]                 r_rel;
    logic [OL-1:0]                 r_click;
    logic [OL-1:0][mchd_pkg::COUNT_W-1:0] r_count;

    logic                          w_move;
    logic                          w_moved;
    logic [OL-1:0]                 n_drag;
    logic [OL-1:0]                 n_hold;
    logic [OL-1:0]                 n_rel;
    logic [OL-1:0]                 n_click;
    logic [OL-1:0][mchd_pkg::COUNT_W-1:0] n_count;

    mchd_pkg::t_lane_res           w_lane [NUM_BUTTONS];

    assign w_move      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_move;
    assign o_cfg_ready = 1'b1;
    assign w_moved     = (r_in_x != r_prev_x) || (r_in_y != r_prev_y);

    mchd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        logic                         w_en;
        logic                         w_now_btn;
        logic                         w_prev_btn;
        logic [mchd_pkg::COUNT_W-1:0] w_limit;
        if (g < OL) begin : g_wired
            assign w_en       = w_cfg.button_en[g];
            assign w_now_btn  = r_in_btn[g];
            assign w_prev_btn = r_prev_btn[g];
            assign w_limit    = w_cfg.max_clicks[g];
        end else begin : g_spare
            assign w_en       = 1'b0;
            assign w_now_btn  = 1'b0;
            assign w_prev_btn = 1'b0;
            assign w_limit    = '0;
        end
        mchd_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_upd         (w_move),
            .i_en          (w_en),
            .i_now_btn     (w_now_btn),
            .i_prev_btn    (w_prev_btn),
            .i_moved       (w_moved),
            .i_now         (r_in_time),
            .i_hold_delay  (w_cfg.hold_delay),
            .i_multi_delay (w_cfg.multi_delay),
            .i_limit       (w_limit),
            .o_res         (w_lane[g])
        );
    end

    for (genvar g = 0; g < OL; g++) begin : g_map
        if (g < NUM_BUTTONS) begin : g_used
            assign n_drag[g]  = w_lane[g].drag;
            assign n_hold[g]  = w_lane[g].hold;
            assign n_rel[g]   = w_lane[g].release_fired;
            assign n_click[g] = w_lane[g].click;
            assign n_count[g] = w_lane[g].count;
        end else begin : g_unused
            assign n_drag[g]  = 1'b0;
            assign n_hold[g]  = 1'b0;
            assign n_rel[g]   = 1'b0;
            assign n_click[g] = 1'b0;
            assign n_count[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_x    <= i_pos_x;
            r_in_y    <= i_pos_y;
            r_in_btn  <= i_button_mask;
            r_in_time <= i_time_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_prev_btn <= '0;
        end else if (w_move) begin
            r_prev_x   <= r_in_x;
            r_prev_y   <= r_in_y;
            r_prev_btn <= r_in_btn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_moved <= w_moved;
            r_drag  <= n_drag;
            r_hold  <= n_hold;
            r_rel   <= n_rel;
            r_click <= n_click;
            r_count <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_moved        = r_moved;
    assign o_drag_mask    = r_drag;
    assign o_hold_mask    = r_hold;
    assign o_release_mask = r_rel;
    assign o_click_mask   = r_click;
    assign o_count_left   = r_count[0];
    assign o_count_right  = r_count[1];
    assign o_count_middle = r_count[2];
    assign o_count_fourth = r_count[3];
    assign o_count_fifth  = r_count[4];

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("Input beat accepted while both stages are stalled.");

    a_drag_needs_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_drag_mask != '0) |-> o_moved)
        else $error("Drag reported without pointer movement.");

    a_count_with_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_count_left != '0) == o_click_mask[0]))
        else $error("Left click count does not match the click mask.");

    a_hold_click_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_hold_mask & (o_click_mask | o_release_mask)) == '0))
        else $error("Hold fired together with a click or release on one button.");

endmodule
